### rtl/salru_pkg.sv
package salru_pkg;

    localparam int SET_BITS_MAX = 6;
    localparam int WAYS_MAX     = 8;

    localparam int ADDR_W     = 64;
    localparam int KIND_W     = 2;
    localparam int CNT_W      = 32;
    localparam int SET_CFG_W  = 3;
    localparam int OFS_CFG_W  = 6;
    localparam int WAYS_CFG_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SPLIT_W    = 7;
    localparam int M_DATA_W   = 104;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_MODIFY = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_META,
        ST_SCAN,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_cmd_t;

    typedef struct packed {
        logic hit;
        logic slot;
    } scan_flags_t;

endpackage

### rtl/salru_ram.sv
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/salru_scan.sv
// One way per step: tag compare, first-invalid search and oldest-way search.
module salru_scan #(
    parameter int WAYS_MAX = salru_pkg::WAYS_MAX
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  salru_pkg::scan_cmd_t                         cmd,
    input  logic [(WAYS_MAX > 1 ? $clog2(WAYS_MAX) : 1)-1:0] way,
    input  logic                                         line_valid,
    input  logic [(WAYS_MAX > 1 ? $clog2(WAYS_MAX) : 1)-1:0] line_age,
    input  logic [salru_pkg::ADDR_W-1:0]                 tag_rd,
    input  logic [salru_pkg::ADDR_W-1:0]                 tag_ref,
    output logic                                         match,
    output salru_pkg::scan_flags_t                       flags,
    output logic [(WAYS_MAX > 1 ? $clog2(WAYS_MAX) : 1)-1:0] hit_way,
    output logic [(WAYS_MAX > 1 ? $clog2(WAYS_MAX) : 1)-1:0] slot_way,
    output logic [(WAYS_MAX > 1 ? $clog2(WAYS_MAX) : 1)-1:0] victim_way
);

    localparam int WAY_W = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;

    salru_pkg::scan_flags_t flags_reg;
    logic [WAY_W-1:0]       hit_way_reg;
    logic [WAY_W-1:0]       slot_way_reg;
    logic [WAY_W-1:0]       victim_way_reg;
    logic [WAY_W-1:0]       victim_age_reg;

    assign match = line_valid && (tag_rd == tag_ref);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (cmd.clear) begin
            flags_reg <= '0;
        end else if (cmd.step) begin
            if (match && !flags_reg.hit) begin
                flags_reg.hit <= 1'b1;
            end
            if (!line_valid && !flags_reg.slot) begin
                flags_reg.slot <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            if (match && !flags_reg.hit) begin
                hit_way_reg <= way;
            end
            if (!line_valid && !flags_reg.slot) begin
                slot_way_reg <= way;
            end
            // ties keep the lower way
            if (way == '0 || line_age > victim_age_reg) begin
                victim_way_reg <= way;
                victim_age_reg <= line_age;
            end
        end
    end

    assign flags      = flags_reg;
    assign hit_way    = hit_way_reg;
    assign slot_way   = slot_way_reg;
    assign victim_way = victim_way_reg;

endmodule

### rtl/set_assoc_cache_lru_tag_model_top.sv
// Channel   Dir  Transaction
// s_        in   tuser = kind, tdata = address
// m_        out  tdata = flags and the three running totals
// cfg_      in   write-only register port, no handshake
//
// Access: k = ways compared (1 up to the ways in use), one per cycle through
// the shared compare unit; an unused kind skips the compare. Input is taken
// only when idle, in the cycle after each result load. Reset is synchronous;
// a per-set flag marks sets touched since reset, so no clearing pass is needed.
// A result may wait in the output register while the next transaction is
// accepted.
module set_assoc_cache_lru_tag_model_top #(
    parameter int SET_BITS_MAX = salru_pkg::SET_BITS_MAX,
    parameter int WAYS_MAX     = salru_pkg::WAYS_MAX
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [salru_pkg::ADDR_W-1:0]        s_tdata,   // [63:0] address
    input  logic [salru_pkg::KIND_W-1:0]        s_tuser,   // [1:0] kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] was_hit, [1] was_miss, [2] was_eviction, [3] second_hit,
    // [35:4] hit_total, [67:36] miss_total, [99:68] eviction_total, rest zero
    output logic [salru_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int NUM_SETS  = 1 << SET_BITS_MAX;
    localparam int SIDX_W    = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
    localparam int NUM_LINES = NUM_SETS * WAYS_MAX;
    localparam int TA_W      = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int WAY_W     = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
    localparam int AGE_W     = WAY_W;
    localparam int WCNT_W    = $clog2(WAYS_MAX + 1);
    localparam int META_W    = WAYS_MAX * (1 + AGE_W);
    localparam int ADDR_W    = salru_pkg::ADDR_W;
    localparam int CNT_W     = salru_pkg::CNT_W;
    localparam int PAD_W     = salru_pkg::M_DATA_W - 4 - 3 * CNT_W;

    // config registers
    logic [salru_pkg::SET_CFG_W-1:0]  cfg_set_reg;
    logic [salru_pkg::OFS_CFG_W-1:0]  cfg_block_reg;
    logic [salru_pkg::WAYS_CFG_W-1:0] cfg_ways_reg;

    salru_pkg::state_t state_reg, state_next;

    salru_pkg::kind_t                 kind_reg;
    logic [ADDR_W-1:0]                addr_reg;
    logic [SIDX_W-1:0]                set_reg;
    logic [ADDR_W-1:0]                tag_reg;
    logic [WCNT_W-1:0]                nways_reg;
    logic [WAY_W-1:0]                 way_reg;
    logic [WAYS_MAX-1:0]              valid_reg;
    logic [WAYS_MAX-1:0][AGE_W-1:0]   age_reg;
    logic [NUM_SETS-1:0]              row_seen_reg;

    logic             hit_reg, miss_reg, evict_reg, second_reg;
    logic [CNT_W-1:0] hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;

    logic                          m_tvalid_reg;
    logic [salru_pkg::M_DATA_W-1:0] m_tdata_reg;

    // split of the address
    logic [salru_pkg::SET_CFG_W-1:0] sbits;
    logic [salru_pkg::SPLIT_W-1:0]   split;
    logic [ADDR_W-1:0]               shifted;
    logic [SIDX_W-1:0]               set_mask;
    logic [SIDX_W-1:0]               set_next;
    logic [ADDR_W-1:0]               tag_next;
    logic [WCNT_W-1:0]               nways_next;

    // memories
    logic                 meta_re, meta_we;
    logic [META_W-1:0]    meta_rdata, meta_wdata;
    logic                 tag_re, tag_we;
    logic [TA_W-1:0]      tag_raddr, tag_waddr;
    logic [ADDR_W-1:0]    tag_rdata;
    logic [WAY_W-1:0]     rd_way;
    logic [WAYS_MAX-1:0]            meta_valid;
    logic [WAYS_MAX-1:0][AGE_W-1:0] meta_age;

    // scan unit
    salru_pkg::scan_cmd_t   scan_cmd;
    salru_pkg::scan_flags_t scan_flags;
    logic                   scan_match;
    logic                   scan_last;
    logic [WAY_W-1:0]       hit_way, slot_way, victim_way;

    // update
    logic [WAY_W-1:0]               target;
    logic                           was_valid;
    logic [AGE_W-1:0]               old_age;
    logic [WAYS_MAX-1:0]            valid_new;
    logic [WAYS_MAX-1:0][AGE_W-1:0] age_new;
    logic                           is_modify;
    logic [1:0]                     hit_inc;
    logic                           miss_inc, evict_inc;
    logic [CNT_W:0]                 hit_sum, miss_sum, evict_sum;
    logic                           load_out;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_set_reg   <= '0;
            cfg_block_reg <= '0;
            cfg_ways_reg  <= salru_pkg::WAYS_CFG_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                salru_pkg::CFG_SET_BITS: begin
                    cfg_set_reg <= cfg_wdata[salru_pkg::SET_CFG_W-1:0];
                end
                salru_pkg::CFG_BLOCK_BITS: begin
                    cfg_block_reg <= cfg_wdata[salru_pkg::OFS_CFG_W-1:0];
                end
                salru_pkg::CFG_WAYS: begin
                    cfg_ways_reg <= cfg_wdata[salru_pkg::WAYS_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- address split ----------------
    always_comb begin
        if (32'(cfg_set_reg) > SET_BITS_MAX) begin
            sbits = salru_pkg::SET_CFG_W'(SET_BITS_MAX);
        end else begin
            sbits = cfg_set_reg;
        end
        if (cfg_ways_reg == '0) begin
            nways_next = WCNT_W'(1);
        end else if (32'(cfg_ways_reg) > WAYS_MAX) begin
            nways_next = WCNT_W'(WAYS_MAX);
        end else begin
            nways_next = WCNT_W'(cfg_ways_reg);
        end
        split    = salru_pkg::SPLIT_W'(sbits) + salru_pkg::SPLIT_W'(cfg_block_reg);
        shifted  = addr_reg >> cfg_block_reg;
        set_mask = SIDX_W'((32'd1 << sbits) - 32'd1);
        set_next = shifted[SIDX_W-1:0] & set_mask;
        tag_next = addr_reg >> split;  // zero once split reaches 64
    end

    // ---------------- memories ----------------
    salru_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_SETS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (set_reg),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (set_next),
        .rdata (meta_rdata)
    );

    salru_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (NUM_LINES)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_reg),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    assign meta_valid = row_seen_reg[set_reg] ? meta_rdata[META_W-1 -: WAYS_MAX] : '0;
    assign meta_age   = meta_rdata[WAYS_MAX*AGE_W-1:0];
    assign tag_raddr  = TA_W'(TA_W'(set_reg) * TA_W'(WAYS_MAX) + TA_W'(rd_way));
    assign tag_waddr  = TA_W'(TA_W'(set_reg) * TA_W'(WAYS_MAX) + TA_W'(target));

    // ---------------- shared compare unit ----------------
    salru_scan #(
        .WAYS_MAX (WAYS_MAX)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (scan_cmd),
        .way        (way_reg),
        .line_valid (valid_reg[way_reg]),
        .line_age   (age_reg[way_reg]),
        .tag_rd     (tag_rdata),
        .tag_ref    (tag_reg),
        .match      (scan_match),
        .flags      (scan_flags),
        .hit_way    (hit_way),
        .slot_way   (slot_way),
        .victim_way (victim_way)
    );

    assign scan_last = (WCNT_W'(way_reg) + WCNT_W'(1)) == nways_reg;

    // ---------------- LRU update ----------------
    always_comb begin
        if (scan_flags.hit) begin
            target = hit_way;
        end else if (scan_flags.slot) begin
            target = slot_way;
        end else begin
            target = victim_way;
        end
        was_valid = scan_flags.hit || !scan_flags.slot;
        old_age   = age_reg[target];
        valid_new = valid_reg;
        age_new   = age_reg;
        for (int v = 0; v < WAYS_MAX; v++) begin
            if (WAY_W'(v) != target && valid_reg[v] && (WCNT_W'(v) < nways_reg)
                && (!was_valid || age_reg[v] < old_age)
                && age_reg[v] < AGE_W'(WAYS_MAX - 1)) begin
                age_new[v] = age_reg[v] + AGE_W'(1);
            end
        end
        valid_new[target] = 1'b1;
        age_new[target]   = '0;
        meta_wdata        = {valid_new, age_new};

        is_modify = (kind_reg == salru_pkg::KIND_MODIFY);
        hit_inc   = {1'b0, scan_flags.hit} + {1'b0, is_modify};
        miss_inc  = !scan_flags.hit;
        evict_inc = !scan_flags.hit && !scan_flags.slot;
        hit_sum   = {1'b0, hit_cnt_reg} + (CNT_W + 1)'(hit_inc);
        miss_sum  = {1'b0, miss_cnt_reg} + (CNT_W + 1)'(miss_inc);
        evict_sum = {1'b0, evict_cnt_reg} + (CNT_W + 1)'(evict_inc);
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            salru_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (salru_pkg::kind_t'(s_tuser) == salru_pkg::KIND_NONE) begin
                        state_next = salru_pkg::ST_RESULT;
                    end else begin
                        state_next = salru_pkg::ST_SPLIT;
                    end
                end
            end
            salru_pkg::ST_SPLIT: begin
                state_next = salru_pkg::ST_META;
            end
            salru_pkg::ST_META: begin
                state_next = salru_pkg::ST_SCAN;
            end
            salru_pkg::ST_SCAN: begin
                if (scan_match || scan_last) begin
                    state_next = salru_pkg::ST_UPDATE;
                end
            end
            salru_pkg::ST_UPDATE: begin
                state_next = salru_pkg::ST_RESULT;
            end
            salru_pkg::ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = salru_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = salru_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        meta_re  = 1'b0;
        meta_we  = 1'b0;
        tag_re   = 1'b0;
        tag_we   = 1'b0;
        rd_way   = '0;
        scan_cmd = '0;
        load_out = 1'b0;
        unique case (state_reg)
            salru_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            salru_pkg::ST_SPLIT: begin
                meta_re = 1'b1;
            end
            salru_pkg::ST_META: begin
                tag_re         = 1'b1;
                scan_cmd.clear = 1'b1;
            end
            salru_pkg::ST_SCAN: begin
                scan_cmd.step = 1'b1;
                rd_way        = way_reg + WAY_W'(1);
                tag_re        = !(scan_match || scan_last);
            end
            salru_pkg::ST_UPDATE: begin
                meta_we = 1'b1;
                tag_we  = !scan_flags.hit;
            end
            salru_pkg::ST_RESULT: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= salru_pkg::ST_IDLE;
            row_seen_reg  <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            hit_reg       <= 1'b0;
            miss_reg      <= 1'b0;
            evict_reg     <= 1'b0;
            second_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_tvalid && s_tready) begin
                hit_reg    <= 1'b0;
                miss_reg   <= 1'b0;
                evict_reg  <= 1'b0;
                second_reg <= 1'b0;
            end
            if (state_reg == salru_pkg::ST_UPDATE) begin
                row_seen_reg[set_reg] <= 1'b1;
                hit_reg       <= scan_flags.hit;
                miss_reg      <= miss_inc;
                evict_reg     <= evict_inc;
                second_reg    <= is_modify;
                hit_cnt_reg   <= hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
                miss_cnt_reg  <= miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
                evict_cnt_reg <= evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg <= salru_pkg::kind_t'(s_tuser);
            addr_reg <= s_tdata;
        end
        if (state_reg == salru_pkg::ST_SPLIT) begin
            set_reg   <= set_next;
            tag_reg   <= tag_next;
            nways_reg <= nways_next;
        end
        if (state_reg == salru_pkg::ST_META) begin
            valid_reg <= meta_valid;
            age_reg   <= meta_age;
            way_reg   <= '0;
        end
        if (state_reg == salru_pkg::ST_SCAN) begin
            way_reg <= way_reg + WAY_W'(1);
        end
        if (load_out) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, evict_cnt_reg, miss_cnt_reg, hit_cnt_reg,
                            second_reg, evict_reg, miss_reg, hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
